### hdl/rtp_pkg.sv
// ----------------------------------------------------------------------------
// rtp_pkg: shared types and defaults for the timestamp parser
// Record passed from the character parser to the epoch converter, result
// format, and queue depth defaults.
// ----------------------------------------------------------------------------
package rtp_pkg;

   localparam int RTP_MID_DEPTH = 4;
   localparam int RTP_OUT_DEPTH = 16;

   localparam int RTP_EPOCH_W = 39;

   typedef struct packed {
      logic        ok;
      logic [13:0] year;
      logic [6:0]  month;
      logic [6:0]  day;
      logic [6:0]  hour;
      logic [6:0]  minute;
      logic [6:0]  second;
      logic        zone_neg;
      logic [6:0]  zone_hour;
      logic [6:0]  zone_minute;
   } rtp_rec_type;

   typedef struct packed {
      logic                          valid_res;
      logic signed [RTP_EPOCH_W-1:0] epoch_seconds;
   } rtp_res_type;

endpackage

### hdl/rfc3339_timestamp_parser_core.sv
// Each string's record passes through the conversion pipeline into the result queue.
// Throughput: a character per cycle unless full; a result per cycle for 1-char strings.
// full rises when the record queue between parser and converter fills, which happens
// only when results are not popped; the converter issues against result-queue credits.
// Reset (synchronous, active high) returns the parser to the start of a string and
// empties both queues and the conversion pipeline.
// ----------------------------------------------------------------------------
// rfc3339_timestamp_parser_core: RFC 3339 timestamp to epoch seconds
// Character parser, record queue, epoch conversion pipeline, result queue.
// ----------------------------------------------------------------------------
module rfc3339_timestamp_parser_core import rtp_pkg::*; #(
   parameter int MID_DEPTH = RTP_MID_DEPTH,
   parameter int OUT_DEPTH = RTP_OUT_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [7:0]                    req_char_code,
   input  logic                          req_is_last,
   output logic                          empty,
   input  logic                          pop,
   output logic                          rsp_valid_res,
   output logic signed [RTP_EPOCH_W-1:0] rsp_epoch_seconds
);

   localparam int REC_W = $bits(rtp_rec_type);
   localparam int RES_W = $bits(rtp_res_type);

   logic             rec_push, rec_pop, rec_empty, mid_full;
   rtp_rec_type      rec_in, rec_out;
   logic [REC_W-1:0] rec_out_bits;
   logic             res_push, res_taken;
   rtp_res_type      res_in, res_out;
   logic [RES_W-1:0] res_out_bits;

   assign full      = mid_full;
   assign rec_out   = rtp_rec_type'(rec_out_bits);
   assign res_out   = rtp_res_type'(res_out_bits);
   assign res_taken = pop & ~empty;

   assign rsp_valid_res     = res_out.valid_res;
   assign rsp_epoch_seconds = res_out.epoch_seconds;

   rtp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (mid_full),
      .char_code (req_char_code),
      .is_last   (req_is_last),
      .rec_push  (rec_push),
      .rec       (rec_in)
   );

   rtp_fifo #(
      .WIDTH (REC_W),
      .DEPTH (MID_DEPTH)
   ) u_rec_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rec_push),
      .push_data (REC_W'(rec_in)),
      .full      (mid_full),
      .pop       (rec_pop),
      .pop_data  (rec_out_bits),
      .empty     (rec_empty)
   );

   rtp_back #(
      .OUT_DEPTH (OUT_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .rec_empty (rec_empty),
      .rec       (rec_out),
      .rec_pop   (rec_pop),
      .res_taken (res_taken),
      .res_push  (res_push),
      .res       (res_in)
   );

   rtp_fifo #(
      .WIDTH (RES_W),
      .DEPTH (OUT_DEPTH)
   ) u_res_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (RES_W'(res_in)),
      .full      (),
      .pop       (pop),
      .pop_data  (res_out_bits),
      .empty     (empty)
   );

endmodule

### hdl/rtp_fifo.sv
// ----------------------------------------------------------------------------
// rtp_fifo: small register queue
// Push/pop queue with count-based full and empty; head entry read directly.
// ----------------------------------------------------------------------------
module rtp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
      if (do_push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

### hdl/rtp_front.sv
// ----------------------------------------------------------------------------
// rtp_front: character parser
// Walks the fixed timestamp layout one character per transfer, accumulates
// the decimal fields and emits one record on the final character.
// ----------------------------------------------------------------------------
module rtp_front import rtp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  logic [7:0]  char_code,
   input  logic        is_last,
   output logic        rec_push,
   output rtp_rec_type rec
);

   localparam logic [4:0] PH_YEAR0      = 5'd0;
   localparam logic [4:0] PH_YEAR3      = 5'd3;
   localparam logic [4:0] PH_MON_DASH   = 5'd4;
   localparam logic [4:0] PH_MON0       = 5'd5;
   localparam logic [4:0] PH_MON1       = 5'd6;
   localparam logic [4:0] PH_DAY_DASH   = 5'd7;
   localparam logic [4:0] PH_DAY0       = 5'd8;
   localparam logic [4:0] PH_DAY1       = 5'd9;
   localparam logic [4:0] PH_T          = 5'd10;
   localparam logic [4:0] PH_HOUR0      = 5'd11;
   localparam logic [4:0] PH_HOUR1      = 5'd12;
   localparam logic [4:0] PH_MIN_COLON  = 5'd13;
   localparam logic [4:0] PH_MIN0       = 5'd14;
   localparam logic [4:0] PH_MIN1       = 5'd15;
   localparam logic [4:0] PH_SEC_COLON  = 5'd16;
   localparam logic [4:0] PH_SEC0       = 5'd17;
   localparam logic [4:0] PH_SEC1       = 5'd18;
   localparam logic [4:0] PH_SEC_END    = 5'd19;
   localparam logic [4:0] PH_FRAC_FIRST = 5'd20;
   localparam logic [4:0] PH_FRAC_MORE  = 5'd21;
   localparam logic [4:0] PH_ZH0        = 5'd22;
   localparam logic [4:0] PH_ZH1        = 5'd23;
   localparam logic [4:0] PH_ZCOLON     = 5'd24;
   localparam logic [4:0] PH_ZM0        = 5'd25;
   localparam logic [4:0] PH_ZM1        = 5'd26;
   localparam logic [4:0] PH_DONE       = 5'd27;

   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_T_UP  = 8'h54;
   localparam logic [7:0] CH_T_LO  = 8'h74;
   localparam logic [7:0] CH_Z_UP  = 8'h5A;
   localparam logic [7:0] CH_Z_LO  = 8'h7A;

   function automatic logic [13:0] acc14(input logic [13:0] a, input logic [3:0] d);
      logic [17:0] t;
      t = 18'(a) * 18'd10 + 18'(d);
      return t[13:0];
   endfunction

   function automatic logic [6:0] acc7(input logic [6:0] a, input logic [3:0] d);
      logic [10:0] t;
      t = 11'(a) * 11'd10 + 11'(d);
      return t[6:0];
   endfunction

   logic [4:0]  phase_ff, phase_in;
   logic [13:0] year_ff, year_in;
   logic [6:0]  month_ff, month_in, day_ff, day_in, hour_ff, hour_in;
   logic [6:0]  minute_ff, minute_in, second_ff, second_in;
   logic [6:0]  zh_ff, zh_in, zm_ff, zm_in;
   logic        neg_ff, neg_in, err_ff, err_in;

   logic        accept, digit;
   logic [3:0]  dv;
   logic [4:0]  ph_next, zs_phase;
   logic        zs_neg, zs_err;

   assign accept  = push & ~full;
   assign digit   = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
   assign dv      = char_code[3:0];
   assign ph_next = phase_ff + 5'd1;

   always_comb begin
      zs_phase = phase_ff;
      zs_neg   = neg_ff;
      zs_err   = 1'b0;
      if (char_code == CH_Z_UP || char_code == CH_Z_LO) begin
         zs_phase = PH_DONE;
      end else if (char_code == CH_PLUS || char_code == CH_DASH) begin
         zs_phase = PH_ZH0;
         zs_neg   = (char_code == CH_DASH);
      end else begin
         zs_err = 1'b1;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      year_in   = year_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      zh_in     = zh_ff;
      zm_in     = zm_ff;
      neg_in    = neg_ff;
      err_in    = err_ff;
      if (!err_ff) begin
         case (phase_ff) inside
            [PH_YEAR0:PH_YEAR3]: begin
               if (digit) begin
                  year_in  = acc14(year_ff, dv);
                  phase_in = ph_next;
               end else err_in = 1'b1;
            end
            PH_MON0, PH_MON1: begin
               if (digit) begin
                  month_in = acc7(month_ff, dv);
                  phase_in = ph_next;
               end else err_in = 1'b1;
            end
            PH_DAY0, PH_DAY1: begin
               if (digit) begin
                  day_in   = acc7(day_ff, dv);
                  phase_in = ph_next;
               end else err_in = 1'b1;
            end
            PH_HOUR0, PH_HOUR1: begin
               if (digit) begin
                  hour_in  = acc7(hour_ff, dv);
                  phase_in = ph_next;
               end else err_in = 1'b1;
            end
            PH_MIN0, PH_MIN1: begin
               if (digit) begin
                  minute_in = acc7(minute_ff, dv);
                  phase_in  = ph_next;
               end else err_in = 1'b1;
            end
            PH_SEC0, PH_SEC1: begin
               if (digit) begin
                  second_in = acc7(second_ff, dv);
                  phase_in  = ph_next;
               end else err_in = 1'b1;
            end
            PH_MON_DASH, PH_DAY_DASH: begin
               if (char_code == CH_DASH) phase_in = ph_next;
               else err_in = 1'b1;
            end
            PH_T: begin
               if (char_code == CH_T_UP || char_code == CH_T_LO) phase_in = ph_next;
               else err_in = 1'b1;
            end
            PH_MIN_COLON, PH_SEC_COLON, PH_ZCOLON: begin
               if (char_code == CH_COLON) phase_in = ph_next;
               else err_in = 1'b1;
            end
            PH_SEC_END: begin
               if (char_code == CH_DOT) begin
                  phase_in = PH_FRAC_FIRST;
               end else begin
                  phase_in = zs_phase;
                  neg_in   = zs_neg;
                  err_in   = zs_err;
               end
            end
            PH_FRAC_FIRST: begin
               if (digit) phase_in = PH_FRAC_MORE;
               else err_in = 1'b1;
            end
            PH_FRAC_MORE: begin
               if (!digit) begin
                  phase_in = zs_phase;
                  neg_in   = zs_neg;
                  err_in   = zs_err;
               end
            end
            PH_ZH0, PH_ZH1: begin
               if (digit) begin
                  zh_in    = acc7(zh_ff, dv);
                  phase_in = ph_next;
               end else err_in = 1'b1;
            end
            PH_ZM0, PH_ZM1: begin
               if (digit) begin
                  zm_in    = acc7(zm_ff, dv);
                  phase_in = ph_next;
               end else err_in = 1'b1;
            end
            default: err_in = 1'b1;
         endcase
      end
   end

   assign rec_push        = accept & is_last;
   assign rec.ok          = ~err_in && (phase_in == PH_DONE);
   assign rec.year        = year_in;
   assign rec.month       = month_in;
   assign rec.day         = day_in;
   assign rec.hour        = hour_in;
   assign rec.minute      = minute_in;
   assign rec.second      = second_in;
   assign rec.zone_neg    = neg_in;
   assign rec.zone_hour   = zh_in;
   assign rec.zone_minute = zm_in;

   always_ff @(posedge clock) begin
      if (reset || (accept && is_last)) begin
         phase_ff  <= PH_YEAR0;
         year_ff   <= '0;
         month_ff  <= '0;
         day_ff    <= '0;
         hour_ff   <= '0;
         minute_ff <= '0;
         second_ff <= '0;
         zh_ff     <= '0;
         zm_ff     <= '0;
         neg_ff    <= 1'b0;
         err_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         year_ff   <= year_in;
         month_ff  <= month_in;
         day_ff    <= day_in;
         hour_ff   <= hour_in;
         minute_ff <= minute_in;
         second_ff <= second_in;
         zh_ff     <= zh_in;
         zm_ff     <= zm_in;
         neg_ff    <= neg_in;
         err_ff    <= err_in;
      end
   end

endmodule

### hdl/rtp_back.sv
// ----------------------------------------------------------------------------
// rtp_back: epoch converter
// Six-stage pipeline: range checks, leap year, era split, day of era,
// day count, scaling to seconds and zone correction. Issue is gated by
// credits for the result queue, so the pipeline never stalls.
// ----------------------------------------------------------------------------
module rtp_back import rtp_pkg::*; #(
   parameter int OUT_DEPTH = RTP_OUT_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        rec_empty,
   input  rtp_rec_type rec,
   output logic        rec_pop,
   input  logic        res_taken,
   output logic        res_push,
   output rtp_res_type res
);

   localparam int CRW = $clog2(OUT_DEPTH + 1);

   function automatic logic [8:0] days_before(input logic [3:0] mp);
      logic [8:0] r;
      unique case (mp)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd31;
         4'd2:    r = 9'd61;
         4'd3:    r = 9'd92;
         4'd4:    r = 9'd122;
         4'd5:    r = 9'd153;
         4'd6:    r = 9'd184;
         4'd7:    r = 9'd214;
         4'd8:    r = 9'd245;
         4'd9:    r = 9'd275;
         4'd10:   r = 9'd306;
         4'd11:   r = 9'd337;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] r;
      unique case (m) inside
         4'd2:                   r = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
         default:                r = 5'd31;
      endcase
      return r;
   endfunction

   logic [CRW-1:0] credit_ff, credit_in;

   // stage 1
   logic               s1_v_ff, s1_ok_ff, s1_neg_ff;
   logic [13:0]        s1_year_ff, s1_yy_ff;
   logic [3:0]         s1_month_ff;
   logic [4:0]         s1_day_ff;
   logic [8:0]         s1_q25_ff, s1_doy_ff;
   logic [16:0]        s1_hms_ff, s1_off_ff;
   // stage 2
   logic               s2_v_ff, s2_ok_ff;
   logic [13:0]        s2_yy_ff;
   logic [4:0]         s2_era_ff;
   logic [8:0]         s2_doy_ff;
   logic signed [18:0] s2_tod_ff;
   // stage 3
   logic               s3_v_ff, s3_ok_ff;
   logic [4:0]         s3_era_ff;
   logic [8:0]         s3_yoe_ff, s3_doy_ff;
   logic signed [18:0] s3_tod_ff;
   // stage 4
   logic               s4_v_ff, s4_ok_ff;
   logic [4:0]         s4_era_ff;
   logic [17:0]        s4_doe_ff;
   logic signed [18:0] s4_tod_ff;
   // stage 5
   logic               s5_v_ff, s5_ok_ff;
   logic signed [23:0] s5_days_ff;
   logic signed [18:0] s5_tod_ff;
   // stage 6
   logic               s6_v_ff, s6_ok_ff;
   logic signed [38:0] s6_prod_ff;
   logic signed [18:0] s6_tod_ff;

   logic               ok1;
   logic [3:0]         mp;
   logic [25:0]        p25;
   logic [13:0]        yy;
   logic [27:0]        pera;
   logic               div25, leap;
   logic signed [18:0] hs, os;
   logic [1:0]         c100;
   logic [22:0]        dsum;
   logic signed [38:0] secs;

   assign rec_pop   = ~rec_empty && (credit_ff < CRW'(OUT_DEPTH));
   assign credit_in = credit_ff + CRW'(rec_pop) - CRW'(res_taken);

   always_comb begin
      ok1 = rec.ok && (rec.month >= 7'd1) && (rec.month <= 7'd12) &&
            (rec.day >= 7'd1) && (rec.day <= 7'd31) && (rec.hour <= 7'd23) &&
            (rec.minute <= 7'd59) && (rec.second <= 7'd60) &&
            (rec.zone_hour <= 7'd23) && (rec.zone_minute <= 7'd59);
      mp   = (rec.month > 7'd2) ? rec.month[3:0] - 4'd3 : rec.month[3:0] + 4'd9;
      p25  = 26'(rec.year) * 26'd5243;
      yy   = rec.year + 14'd400 - ((rec.month <= 7'd2) ? 14'd1 : 14'd0);
      pera = 28'(s1_yy_ff) * 28'd10486;
      div25 = ((14'(s1_q25_ff) * 14'd25) == s1_year_ff);
      leap  = (s1_year_ff[1:0] == 2'd0) && (!div25 || (s1_year_ff[3:0] == 4'd0));
      hs = $signed({2'b00, s1_hms_ff});
      os = $signed({2'b00, s1_off_ff});
      if (s3_yoe_ff >= 9'd300)      c100 = 2'd3;
      else if (s3_yoe_ff >= 9'd200) c100 = 2'd2;
      else if (s3_yoe_ff >= 9'd100) c100 = 2'd1;
      else                          c100 = 2'd0;
      dsum = 23'(s4_era_ff) * 23'd146097 + 23'(s4_doe_ff);
      secs = s6_prod_ff + 39'(s6_tod_ff);
   end

   assign res_push          = s6_v_ff;
   assign res.valid_res     = s6_ok_ff;
   assign res.epoch_seconds = s6_ok_ff ? secs : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
         s1_v_ff   <= 1'b0;
         s2_v_ff   <= 1'b0;
         s3_v_ff   <= 1'b0;
         s4_v_ff   <= 1'b0;
         s5_v_ff   <= 1'b0;
         s6_v_ff   <= 1'b0;
      end else begin
         credit_ff <= credit_in;
         s1_v_ff   <= rec_pop;
         s2_v_ff   <= s1_v_ff;
         s3_v_ff   <= s2_v_ff;
         s4_v_ff   <= s3_v_ff;
         s5_v_ff   <= s4_v_ff;
         s6_v_ff   <= s5_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ok_ff    <= ok1;
      s1_neg_ff   <= rec.zone_neg;
      s1_year_ff  <= rec.year;
      s1_yy_ff    <= yy;
      s1_month_ff <= rec.month[3:0];
      s1_day_ff   <= rec.day[4:0];
      s1_q25_ff   <= p25[25:17];
      s1_doy_ff   <= days_before(mp) + 9'(rec.day[4:0]) - 9'd1;
      s1_hms_ff   <= 17'(rec.hour) * 17'd3600 + 17'(rec.minute) * 17'd60 +
                     17'(rec.second);
      s1_off_ff   <= 17'(rec.zone_hour) * 17'd3600 + 17'(rec.zone_minute) * 17'd60;

      s2_ok_ff  <= s1_ok_ff && (s1_day_ff <= month_len(s1_month_ff, leap));
      s2_yy_ff  <= s1_yy_ff;
      s2_era_ff <= pera[26:22];
      s2_doy_ff <= s1_doy_ff;
      s2_tod_ff <= s1_neg_ff ? hs + os : hs - os;

      s3_ok_ff  <= s2_ok_ff;
      s3_era_ff <= s2_era_ff;
      s3_yoe_ff <= 9'(s2_yy_ff - 14'(s2_era_ff) * 14'd400);
      s3_doy_ff <= s2_doy_ff;
      s3_tod_ff <= s2_tod_ff;

      s4_ok_ff  <= s3_ok_ff;
      s4_era_ff <= s3_era_ff;
      s4_doe_ff <= 18'(s3_yoe_ff) * 18'd365 + 18'(s3_yoe_ff[8:2]) - 18'(c100) +
                   18'(s3_doy_ff);
      s4_tod_ff <= s3_tod_ff;

      s5_ok_ff   <= s4_ok_ff;
      s5_days_ff <= $signed({1'b0, dsum}) - 24'sd865565;
      s5_tod_ff  <= s4_tod_ff;

      s6_ok_ff   <= s5_ok_ff;
      s6_prod_ff <= 39'(s5_days_ff) * 39'sd86400;
      s6_tod_ff  <= s5_tod_ff;
   end

endmodule

### hdl/rtp_checker.sv
// ----------------------------------------------------------------------------
// rtp_checker: port-level checks for the timestamp parser
// Watches the result queue and reset behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
module rtp_checker import rtp_pkg::*; (
   input logic                          clock,
   input logic                          reset,
   input logic                          full,
   input logic                          empty,
   input logic                          pop,
   input logic                          rsp_valid_res,
   input logic signed [RTP_EPOCH_W-1:0] rsp_epoch_seconds
);

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty)
      else $error("result withdrawn before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> $stable(rsp_valid_res) && $stable(rsp_epoch_seconds))
      else $error("result changed while waiting");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      !empty && !rsp_valid_res |-> rsp_epoch_seconds == '0)
      else $error("invalid result carries nonzero seconds");

   a_valid_range: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_valid_res |->
         (rsp_epoch_seconds >= -39'sd62167305540) &&
         (rsp_epoch_seconds <= 39'sd253402387140))
      else $error("valid result outside representable date range");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> empty && !full)
      else $error("queues not cleared by reset");

endmodule

bind rfc3339_timestamp_parser_core rtp_checker u_rtp_checker (.*);
